// ===== design/ripv2_packet_parser_macros.svh =====
// assertion macros for the ripv2 packet parser
`ifndef RIPV2_PACKET_PARSER_MACROS_SVH
`define RIPV2_PACKET_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
`define RPP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ripv2 parser check failed");
`define RPP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ripv2 parser check failed");
`else
`define RPP_ASSERT(lbl, prop)
`define RPP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== design/rpp_pkg.sv =====
// constants and result type for the ripv2 packet parser
package rpp_pkg;

  localparam int ENTRY_BYTES = 20;
  localparam int UDP_BYTES   = 8;
  localparam int METRIC_MAX  = 16;
  localparam int MAX_ENTRIES = 25;
  localparam int FIFO_DEPTH  = 4;

  localparam logic [7:0] CMD_REQUEST  = 8'd1;
  localparam logic [7:0] CMD_RESPONSE = 8'd2;
  localparam logic [7:0] RIP_VERSION  = 8'd2;

  typedef struct packed {
    logic        is_verdict;
    logic [4:0]  entry_index;
    logic [31:0] route_address;
    logic [31:0] route_mask;
    logic [31:0] next_hop;
    logic [31:0] route_metric;
    logic [7:0]  command_code;
    logic        packet_valid;
    logic [4:0]  entry_count;
    logic        last;
  } res_t;

  // wire byte 0 sits in bits 7:0; return the big-endian value
  function automatic logic [31:0] be32(input logic [31:0] w);
    be32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ===== design/ripv2_packet_parser.sv =====
// ripv2 packet parser: byte-stream validation of ipv4/udp/rip v2 packets
//
// Takes one packet byte per cycle on the slave side while tready is high,
// tlast on the final byte of the buffer. Every route entry of a packet not
// yet failed that passes its checks is sent as a word with tuser 0 as soon
// as its twentieth byte arrives; the byte carrying tlast also produces a
// verdict word (tuser 1, tlast 1) with packet_valid, the entry count and
// the command. All checks for a byte are done in the cycle it is accepted
// and the resulting words are registered into a four-word output queue.
// tready drops only while the queue holds more than two words, which
// happens only when the master side stalls.
`include "ripv2_packet_parser_macros.svh"

module ripv2_packet_parser #(
  parameter int MAX_ENTRIES = rpp_pkg::MAX_ENTRIES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // entry_index, route_address, route_mask, next_hop, route_metric,
  // command_code, packet_valid, entry_count, zero pad
  output logic [151:0] m_axis_tdata,
  output logic [0:0]   m_axis_tuser,   // is_verdict
  output logic         m_axis_tlast    // last
);

  localparam int PtrW = $clog2(rpp_pkg::FIFO_DEPTH);
  localparam int CntW = $clog2(rpp_pkg::FIFO_DEPTH + 1);

  // parse state
  logic [15:0] byte_offset, byte_offset_next;
  logic [15:0] total_length, total_length_next;
  logic [3:0]  header_words, header_words_next;
  logic [7:0]  rip_command, rip_command_next;
  logic [4:0]  entry_byte_pos, entry_byte_pos_next;
  logic [31:0] family_tag_shift, family_tag_shift_next;
  logic [31:0] address_shift, address_shift_next;
  logic [31:0] mask_shift, mask_shift_next;
  logic [31:0] hop_shift, hop_shift_next;
  logic [31:0] metric_shift, metric_shift_next;
  logic [4:0]  parsed_entries, parsed_entries_next;
  logic        packet_failed, packet_failed_next;

  // output queue
  rpp_pkg::res_t slot [rpp_pkg::FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  logic        acc, pop, fin, emit, verdict_ok;
  logic [7:0]  b;
  logic [15:0] o, rs16, es16;
  logic [6:0]  rs;
  logic [31:0] ft_be, inv_mask, metric_word, metric_be, want_family;
  logic        entry_good;
  rpp_pkg::res_t ent_res, ver_res;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign pop = m_axis_tvalid && m_axis_tready;
  assign b   = s_axis_tdata;
  assign fin = s_axis_tlast;
  assign o   = byte_offset;

  // rip header starts after the ip header and the udp header
  assign rs   = {1'b0, header_words, 2'b00} + 7'(rpp_pkg::UDP_BYTES);
  assign rs16 = 16'(rs);
  assign es16 = rs16 + 16'd4;

  // entry checks, evaluated on the twentieth byte (metric low byte is b)
  assign ft_be       = rpp_pkg::be32(family_tag_shift);
  assign inv_mask    = ~rpp_pkg::be32(mask_shift);
  assign metric_word = {b, metric_shift[31:8]};
  assign metric_be   = rpp_pkg::be32(metric_word);
  assign want_family = (32'(rip_command) - 32'd1) << 1;
  assign entry_good  = ({16'd0, ft_be[31:16]} == want_family) &&
                       (ft_be[15:0] == 16'd0) &&
                       ((inv_mask & (inv_mask + 32'd1)) == 32'd0) &&
                       (metric_be != 32'd0) &&
                       (metric_be <= 32'(rpp_pkg::METRIC_MAX));

  always_comb begin
    byte_offset_next      = (o != 16'hffff) ? o + 16'd1 : o;
    total_length_next     = total_length;
    header_words_next     = header_words;
    rip_command_next      = rip_command;
    entry_byte_pos_next   = entry_byte_pos;
    family_tag_shift_next = family_tag_shift;
    address_shift_next    = address_shift;
    mask_shift_next       = mask_shift;
    hop_shift_next        = hop_shift;
    metric_shift_next     = metric_shift;
    parsed_entries_next   = parsed_entries;
    packet_failed_next    = packet_failed;
    emit                  = 1'b0;

    if (o == 16'd0) header_words_next = b[3:0];
    if (o == 16'd2) total_length_next[15:8] = b;
    if (o == 16'd3) total_length_next[7:0] = b;

    if (o == rs16) begin
      rip_command_next = b;
      if (b != rpp_pkg::CMD_REQUEST && b != rpp_pkg::CMD_RESPONSE) packet_failed_next = 1'b1;
    end
    if (o == rs16 + 16'd1 && b != rpp_pkg::RIP_VERSION) packet_failed_next = 1'b1;
    if ((o == rs16 + 16'd2 || o == rs16 + 16'd3) && b != 8'd0) packet_failed_next = 1'b1;

    if (o >= es16) begin
      // bytes at or past total length are padding
      if (o < total_length) begin
        if (entry_byte_pos == 5'd0) begin
          if (17'(o) + 17'(rpp_pkg::ENTRY_BYTES) > 17'(total_length))
            packet_failed_next = 1'b1;
          if (parsed_entries >= 5'(MAX_ENTRIES)) packet_failed_next = 1'b1;
        end
        case (entry_byte_pos[4:2])
          3'd0:    family_tag_shift_next = {b, family_tag_shift[31:8]};
          3'd1:    address_shift_next    = {b, address_shift[31:8]};
          3'd2:    mask_shift_next       = {b, mask_shift[31:8]};
          3'd3:    hop_shift_next        = {b, hop_shift[31:8]};
          default: metric_shift_next     = metric_word;
        endcase
        if (entry_byte_pos == 5'(rpp_pkg::ENTRY_BYTES - 1) && !packet_failed_next) begin
          if (entry_good) begin
            emit                = 1'b1;
            parsed_entries_next = parsed_entries + 5'd1;
          end else begin
            packet_failed_next = 1'b1;
          end
        end
      end
      entry_byte_pos_next = (entry_byte_pos >= 5'(rpp_pkg::ENTRY_BYTES - 1)) ?
                            5'd0 : entry_byte_pos + 5'd1;
    end
  end

  assign verdict_ok = !packet_failed_next &&
                      (17'(total_length_next) <= 17'(o) + 17'd1) &&
                      (o >= rs16 + 16'd3);

  always_comb begin
    ent_res               = '0;
    ent_res.entry_index   = parsed_entries;
    ent_res.route_address = address_shift;
    ent_res.route_mask    = mask_shift;
    ent_res.next_hop      = hop_shift;
    ent_res.route_metric  = metric_word;
    ent_res.command_code  = rip_command;
    ent_res.last          = !fin;

    ver_res              = '0;
    ver_res.is_verdict   = 1'b1;
    ver_res.command_code = rip_command_next;
    ver_res.packet_valid = verdict_ok;
    ver_res.entry_count  = parsed_entries_next;
    ver_res.last         = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset      <= '0;
      total_length     <= '0;
      header_words     <= '0;
      rip_command      <= '0;
      entry_byte_pos   <= '0;
      family_tag_shift <= '0;
      address_shift    <= '0;
      mask_shift       <= '0;
      hop_shift        <= '0;
      metric_shift     <= '0;
      parsed_entries   <= '0;
      packet_failed    <= 1'b0;
    end else if (acc) begin
      if (fin) begin
        // packet done, start over
        byte_offset      <= '0;
        total_length     <= '0;
        header_words     <= '0;
        rip_command      <= '0;
        entry_byte_pos   <= '0;
        family_tag_shift <= '0;
        address_shift    <= '0;
        mask_shift       <= '0;
        hop_shift        <= '0;
        metric_shift     <= '0;
        parsed_entries   <= '0;
        packet_failed    <= 1'b0;
      end else begin
        byte_offset      <= byte_offset_next;
        total_length     <= total_length_next;
        header_words     <= header_words_next;
        rip_command      <= rip_command_next;
        entry_byte_pos   <= entry_byte_pos_next;
        family_tag_shift <= family_tag_shift_next;
        address_shift    <= address_shift_next;
        mask_shift       <= mask_shift_next;
        hop_shift        <= hop_shift_next;
        metric_shift     <= metric_shift_next;
        parsed_entries   <= parsed_entries_next;
        packet_failed    <= packet_failed_next;
      end
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (acc && emit) slot[wr_ptr] <= ent_res;
    if (acc && fin) begin
      if (emit) slot[wr_ptr + PtrW'(1)] <= ver_res;
      else      slot[wr_ptr] <= ver_res;
    end
  end

  logic [1:0] n_push;
  assign n_push = acc ? (2'(emit) + 2'(fin)) : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(n_push);
      if (pop) rd_ptr <= rd_ptr + PtrW'(1);
      count <= count + CntW'(n_push) - CntW'(pop);
    end
  end

  // room for an entry word and a verdict word
  assign s_axis_tready = (count <= CntW'(rpp_pkg::FIFO_DEPTH - 2));
  assign m_axis_tvalid = (count != '0);

  rpp_pkg::res_t head;
  assign head = slot[rd_ptr];

  assign m_axis_tdata = {5'd0, head.entry_count, head.packet_valid, head.command_code,
                         head.route_metric, head.next_hop, head.route_mask,
                         head.route_address, head.entry_index};
  assign m_axis_tuser = head.is_verdict;
  assign m_axis_tlast = head.last;

  `RPP_ASSERT(a_count_bound, count <= CntW'(rpp_pkg::FIFO_DEPTH))
  `RPP_ASSERT(a_restart_after_last, (acc && fin) |=> (byte_offset == 16'd0 && parsed_entries == 5'd0))
  `RPP_ASSERT(a_entries_bound, parsed_entries <= 5'(MAX_ENTRIES))
  `RPP_ASSERT(a_verdict_is_last, (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
  `RPP_ASSERT(a_entry_pos_bound, entry_byte_pos < 5'(rpp_pkg::ENTRY_BYTES))

endmodule

// ===== tb/tb_ripv2_packet_parser.sv =====
// self-checking testbench for the ripv2 packet parser: packet streams against a byte-level predictor
module tb_ripv2_packet_parser;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int TOTAL_BYTES  = 1100;
  localparam int RAND_PACKETS = 3;

  class RipRouteScoreboard;
    rpp_pkg::res_t route_words_due[$];
    int unsigned offset;
    bit [15:0]   tot_len;
    bit [3:0]    hdr_words;
    int unsigned cmd;
    int unsigned epos;
    bit [31:0]   ft_sh, addr_sh, mask_sh, hop_sh, met_sh;
    int unsigned n_entries;
    bit          failed;
    int          errors = 0;
    int          shown = 0;

    function new();
      clear();
    endfunction

    function void clear();
      offset = 0;
      tot_len = 0;
      hdr_words = 0;
      cmd = 0;
      epos = 0;
      ft_sh = 0;
      addr_sh = 0;
      mask_sh = 0;
      hop_sh = 0;
      met_sh = 0;
      n_entries = 0;
      failed = 0;
    endfunction

    static function bit [31:0] swap32(bit [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function void push_word(bit verdict, bit [4:0] idx, bit [31:0] a, bit [31:0] m,
                            bit [31:0] h, bit [31:0] met, bit ok, bit [4:0] cnt, bit lst);
      rpp_pkg::res_t w;
      w.is_verdict = verdict;
      w.entry_index = idx;
      w.route_address = a;
      w.route_mask = m;
      w.next_hop = h;
      w.route_metric = met;
      w.command_code = 8'(cmd);
      w.packet_valid = ok;
      w.entry_count = cnt;
      w.last = lst;
      route_words_due.push_back(w);
    endfunction

    // works out the route and verdict words caused by one accepted byte
    function void take_byte(logic [7:0] b, logic fin);
      int unsigned o, rs, es, p;
      bit [31:0]   ft, inv, met, want;
      bit          pass;
      o = offset;
      rs = int'(hdr_words) * 4 + rpp_pkg::UDP_BYTES;
      es = rs + 4;
      if (o == 0) hdr_words = b[3:0];
      if (o == 2) tot_len = {b, tot_len[7:0]};
      if (o == 3) tot_len = {tot_len[15:8], b};
      if (o == rs) begin
        cmd = b;
        if (b != rpp_pkg::CMD_REQUEST && b != rpp_pkg::CMD_RESPONSE) failed = 1;
      end
      if (o == rs + 1 && b != rpp_pkg::RIP_VERSION) failed = 1;
      if ((o == rs + 2 || o == rs + 3) && b != 8'h00) failed = 1;
      if (o >= es) begin
        p = epos;
        if (o < tot_len) begin
          if (p == 0) begin
            if (o + rpp_pkg::ENTRY_BYTES > tot_len) failed = 1;
            if (n_entries >= rpp_pkg::MAX_ENTRIES) failed = 1;
          end
          case (p / 4)
            0: ft_sh = {b, ft_sh[31:8]};
            1: addr_sh = {b, addr_sh[31:8]};
            2: mask_sh = {b, mask_sh[31:8]};
            3: hop_sh = {b, hop_sh[31:8]};
            default: met_sh = {b, met_sh[31:8]};
          endcase
          if (p == rpp_pkg::ENTRY_BYTES - 1 && !failed) begin
            ft = swap32(ft_sh);
            inv = ~swap32(mask_sh);
            met = swap32(met_sh);
            want = (cmd - 1) << 1;
            // mask must be ones from the top: its inverse is a low run of ones
            pass = (ft >> 16) == want && ft[15:0] == 16'h0 && (inv & (inv + 1)) == 0 &&
                   met != 0 && met <= rpp_pkg::METRIC_MAX;
            if (pass) begin
              push_word(1'b0, 5'(n_entries), addr_sh, mask_sh, hop_sh, met_sh,
                        1'b0, 5'd0, !fin);
              n_entries = (n_entries + 1) & 5'h1f;
            end else begin
              failed = 1;
            end
          end
        end
        epos = (p >= rpp_pkg::ENTRY_BYTES - 1) ? 0 : p + 1;
      end
      if (offset < 32'hffff) offset++;
      if (fin) begin
        push_word(1'b1, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                  !failed && tot_len <= o + 1 && o >= rs + 3, 5'(n_entries), 1'b1);
        clear();
      end
    endfunction

    function void compare_word(rpp_pkg::res_t got);
      rpp_pkg::res_t w;
      bit   bad;
      if (route_words_due.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected word: v=%0d idx=%0d a=%h m=%h h=%h met=%h cmd=%h ok=%0d n=%0d l=%0d",
                   got.is_verdict, got.entry_index, got.route_address, got.route_mask,
                   got.next_hop, got.route_metric, got.command_code, got.packet_valid,
                   got.entry_count, got.last);
        end
        return;
      end
      w = route_words_due.pop_front();
      bad = 0;
      if (got.is_verdict !== w.is_verdict) bad = 1;
      if (got.entry_index !== w.entry_index) bad = 1;
      if (got.route_address !== w.route_address) bad = 1;
      if (got.route_mask !== w.route_mask) bad = 1;
      if (got.next_hop !== w.next_hop) bad = 1;
      if (got.route_metric !== w.route_metric) bad = 1;
      if (got.command_code !== w.command_code) bad = 1;
      if (got.packet_valid !== w.packet_valid) bad = 1;
      if (got.entry_count !== w.entry_count) bad = 1;
      if (got.last !== w.last) bad = 1;
      if (bad) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch exp: v=%0d idx=%0d a=%h m=%h h=%h met=%h cmd=%h ok=%0d n=%0d l=%0d",
                   w.is_verdict, w.entry_index, w.route_address, w.route_mask, w.next_hop,
                   w.route_metric, w.command_code, w.packet_valid, w.entry_count, w.last);
          $display("         got: v=%0d idx=%0d a=%h m=%h h=%h met=%h cmd=%h ok=%0d n=%0d l=%0d",
                   got.is_verdict, got.entry_index, got.route_address, got.route_mask,
                   got.next_hop, got.route_metric, got.command_code, got.packet_valid,
                   got.entry_count, got.last);
        end
      end
    endfunction

    function int pending();
      return route_words_due.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [151:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         m_axis_tlast;

  RipRouteScoreboard sb = new();
  logic [7:0]        pkt[$];
  bit                calm = 1'b0;
  int                rdy_hold = 0;
  int                cycles = 0;
  int                sent_bytes = 0;
  int                rand_packets = 0;
  rpp_pkg::res_t     mon_word;

  ripv2_packet_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void push32(bit [31:0] w);
    pkt.push_back(w[31:24]);
    pkt.push_back(w[23:16]);
    pkt.push_back(w[15:8]);
    pkt.push_back(w[7:0]);
  endfunction

  function automatic void put_entry(bit [15:0] fam, bit [15:0] tag, bit [31:0] addr,
                                    bit [31:0] mask, bit [31:0] hop, bit [31:0] met);
    push32({fam, tag});
    push32(addr);
    push32(mask);
    push32(hop);
    push32(met);
  endfunction

  // random route entry, with one broken field when flawed is set
  function automatic void add_entry(logic [7:0] cmd, bit flawed);
    int        plen;
    bit [15:0] fam, tag;
    bit [31:0] mask, met;
    plen = $urandom_range(0, 32);
    mask = (plen == 0) ? 32'h0 : ~32'h0 << (32 - plen);
    fam = 16'((cmd - 8'd1) * 2);
    tag = 16'h0;
    met = $urandom_range(1, rpp_pkg::METRIC_MAX);
    if (flawed) begin
      case ($urandom_range(0, 3))
        0: fam = 16'($urandom);
        1: tag = 16'($urandom_range(1, 16'hffff));
        2: mask = $urandom;
        default: met = ($urandom_range(0, 1) == 0) ? 32'h0 :
                       $urandom_range(rpp_pkg::METRIC_MAX + 1, 32'hffffffff);
      endcase
    end
    put_entry(fam, tag, $urandom, mask, $urandom, met);
  endfunction

  function automatic void set_total(int tot);
    pkt[2] = tot[15:8];
    pkt[3] = tot[7:0];
  endfunction

  function automatic void make_good(int hw, logic [7:0] cmd, int n);
    int tot;
    tot = hw * 4 + rpp_pkg::UDP_BYTES + 4 + rpp_pkg::ENTRY_BYTES * n;
    pkt.delete();
    pkt.push_back((8'($urandom) & 8'hf0) | 8'(hw));
    pkt.push_back(8'($urandom));
    pkt.push_back(tot[15:8]);
    pkt.push_back(tot[7:0]);
    while (pkt.size() < hw * 4 + rpp_pkg::UDP_BYTES) pkt.push_back(8'($urandom));
    pkt.push_back(cmd);
    pkt.push_back(rpp_pkg::RIP_VERSION);
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    repeat (n) add_entry(cmd, 1'b0);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.take_byte(b, fin);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) push_byte(pkt[i], i == pkt.size() - 1);
    sent_bytes += pkt.size();
  endtask

  task automatic random_packet();
    int        r, hw, n, idx, cut;
    logic [7:0] cmd;
    r = $urandom_range(0, 99);
    if (r >= 92) begin
      // plain noise
      pkt.delete();
      repeat ($urandom_range(1, 60)) pkt.push_back(8'($urandom));
    end else begin
      hw = ($urandom_range(0, 1) == 0) ? 5 : $urandom_range(0, 15);
      cmd = ($urandom_range(0, 1) == 0) ? rpp_pkg::CMD_REQUEST : rpp_pkg::CMD_RESPONSE;
      idx = $urandom_range(0, 99);
      n = (idx < 70) ? $urandom_range(0, 2) :
          (idx < 95) ? $urandom_range(3, 5) : $urandom_range(6, rpp_pkg::MAX_ENTRIES + 2);
      make_good(hw, cmd, 0);
      set_total(hw * 4 + rpp_pkg::UDP_BYTES + 4 + rpp_pkg::ENTRY_BYTES * n);
      repeat (n) add_entry(cmd, $urandom_range(0, 99) < 5);
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 10)) pkt.push_back(8'($urandom));
      if (r >= 60 && r < 70) begin
        idx = $urandom_range(0, pkt.size() - 1);
        pkt[idx] = pkt[idx] ^ 8'($urandom_range(1, 255));
      end else if (r >= 70 && r < 78) begin
        cut = $urandom_range(1, pkt.size() - 1);
        repeat (cut) void'(pkt.pop_back());
      end else if (r >= 78 && r < 85) begin
        set_total($urandom_range(0, pkt.size() + 30));
      end else if (r >= 85) begin
        if ($urandom_range(0, 1) == 0) pkt[hw * 4 + rpp_pkg::UDP_BYTES] = 8'($urandom);
        else pkt[hw * 4 + rpp_pkg::UDP_BYTES + 1] = 8'($urandom);
      end
    end
    send_packet();
    rand_packets++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (rdy_hold != 0) begin
      rdy_hold <= rdy_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < 70);
      rdy_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      mon_word.is_verdict = m_axis_tuser[0];
      mon_word.entry_index = m_axis_tdata[4:0];
      mon_word.route_address = m_axis_tdata[36:5];
      mon_word.route_mask = m_axis_tdata[68:37];
      mon_word.next_hop = m_axis_tdata[100:69];
      mon_word.route_metric = m_axis_tdata[132:101];
      mon_word.command_code = m_axis_tdata[140:133];
      mon_word.packet_valid = m_axis_tdata[141];
      mon_word.entry_count = m_axis_tdata[146:142];
      mon_word.last = m_axis_tlast;
      sb.compare_word(mon_word);
    end
  end

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= 8'h00;
    s_axis_tlast <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // entry words at their extremes
    make_good(5, rpp_pkg::CMD_RESPONSE, 0);
    put_entry(16'd2, 16'd0, 32'hffffffff, 32'hffffffff, 32'h0, rpp_pkg::METRIC_MAX);
    set_total(pkt.size());
    send_packet();
    make_good(0, rpp_pkg::CMD_REQUEST, 0);
    put_entry(16'd0, 16'd0, 32'h0, 32'h0, 32'hffffffff, 32'd1);
    set_total(pkt.size());
    send_packet();

    // broken rip header fields
    for (int k = 0; k < 6; k++) begin
      make_good(0, rpp_pkg::CMD_RESPONSE, 0);
      case (k)
        0: pkt[8] = 8'd0;
        1: pkt[8] = 8'd3;
        2: pkt[8] = 8'hff;
        3: pkt[9] = 8'd1;
        4: pkt[10] = 8'h80;
        default: pkt[11] = 8'h01;
      endcase
      send_packet();
    end

    // one entry with a single bad field; the first also has good entries around it
    for (int k = 0; k < 7; k++) begin
      make_good(0, rpp_pkg::CMD_RESPONSE, 0);
      if (k == 0) add_entry(rpp_pkg::CMD_RESPONSE, 1'b0);
      case (k)
        0: put_entry(16'd2, 16'd0, $urandom, 32'hffffff00, $urandom, rpp_pkg::METRIC_MAX + 1);
        1: put_entry(16'd2, 16'd0, $urandom, 32'hffffff00, $urandom, 32'd0);
        2: put_entry(16'd2, 16'd0, $urandom, 32'hffffff00, $urandom, 32'h00010005);
        3: put_entry(16'd2, 16'd0, $urandom, 32'hff00ff00, $urandom, 32'd3);
        4: put_entry(16'd2, 16'd1, $urandom, 32'hffff0000, $urandom, 32'd3);
        5: put_entry(16'd0, 16'd0, $urandom, 32'hffff0000, $urandom, 32'd3);
        default: put_entry(16'd2, 16'd0, $urandom, 32'h7fffffff, $urandom, 32'd3);
      endcase
      if (k == 0) add_entry(rpp_pkg::CMD_RESPONSE, 1'b0);
      set_total(pkt.size());
      send_packet();
    end

    // total length past the buffer
    make_good(0, rpp_pkg::CMD_RESPONSE, 1);
    set_total(pkt.size() + 1);
    send_packet();

    // short buffers: one byte, rip header one byte short, header only
    pkt.delete();
    pkt.push_back(8'h45);
    send_packet();
    make_good(0, rpp_pkg::CMD_RESPONSE, 0);
    void'(pkt.pop_back());
    send_packet();
    make_good(0, rpp_pkg::CMD_REQUEST, 0);
    send_packet();

    // entry cut off by the total length, with and without bytes after it
    make_good(0, rpp_pkg::CMD_RESPONSE, 1);
    set_total(pkt.size() - 10);
    repeat (10) void'(pkt.pop_back());
    send_packet();
    make_good(0, rpp_pkg::CMD_RESPONSE, 1);
    set_total(pkt.size() - 10);
    send_packet();

    // full table followed by one entry too many
    make_good(0, rpp_pkg::CMD_RESPONSE, rpp_pkg::MAX_ENTRIES + 1);
    send_packet();

    // total length inside the ip header: entries after it are ignored
    make_good(5, rpp_pkg::CMD_RESPONSE, 2);
    set_total(10);
    send_packet();

    // padding after the total length
    make_good(0, rpp_pkg::CMD_REQUEST, 2);
    repeat (7) pkt.push_back(8'($urandom));
    send_packet();

    while (sent_bytes < TOTAL_BYTES || rand_packets < RAND_PACKETS) begin
      if ($urandom_range(0, 3) == 0) calm <= ~calm;
      random_packet();
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
    calm <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
